// File: design/wpwe_pkg.sv
// Shared types, field widths and command and status codes for the weighted pick block.
package wpwe_pkg;

	localparam int NUM_ENTRIES_DEF = 1024;
	localparam int WEIGHT_BITS_DEF = 16;

	localparam int CMD_W    = 3;
	localparam int IDX_W    = 10;
	localparam int WIN_W    = 16;
	localparam int DRAW_W   = 26;
	localparam int STATUS_W = 2;
	localparam int TOTAL_W  = 26;

	localparam logic [CMD_W-1:0] CMD_WRITE    = 3'd0;
	localparam logic [CMD_W-1:0] CMD_SET_EXCL = 3'd1;
	localparam logic [CMD_W-1:0] CMD_CLR_EXCL = 3'd2;
	localparam logic [CMD_W-1:0] CMD_CLR_ALL  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_DRAW     = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [IDX_W-1:0]  entry_index;
		logic [WIN_W-1:0]  weight_value;
		logic [DRAW_W-1:0] draw_value;
	} req_t;

	typedef struct packed {
		logic [IDX_W-1:0]    picked_index;
		logic [STATUS_W-1:0] status;
		logic [TOTAL_W-1:0]  total_weight;
	} rsp_t;

endpackage

// File: design/weighted_pick_with_exclusions.sv
// Weighted random pick over a weight table with per-entry exclusion marks.
//
// This block keeps NUM_ENTRIES weights of WEIGHT_BITS bits each, plus one exclusion mark per
// entry, in two simple dual-port synchronous memories. Each request transaction carries a
// command: write a weight, set or clear one exclusion mark, clear all marks, or draw. Every
// request yields exactly one response transaction. Non-draw commands answer with status ok
// and zero fields; writes, sets and clears aimed beyond the table change nothing. A draw walks
// the whole table in index order, one entry per cycle through the memory read port, adding the
// weights of entries that are not excluded and remembering the first index at which the
// running sum exceeds the supplied draw value. At the end of the walk it reports that index
// with the eligible total (saturated to 26 bits), or status "no remaining weight" when the
// total is zero, or status "draw not below total" when the draw value is too large.
// Sequencing: a write, set, clear or unused command offers its response once its result
// has moved from the pending register into the output register, and the next request can
// be accepted only after that move. A draw offers its response once the walk has passed its
// last entry through the read registers; the next request follows once that result moves on.
// A clear-all offers its response without waiting for its sweep of the marks, but the sweep
// keeps the input stalled until every entry is cleared. All of this is bound by the one read
// and one write per cycle of the memories. After reset a clearing pass zeroes both memories,
// during which no request is accepted. A finished response waits in an output register, so
// the next request may be accepted and worked on while it is still stalled.
module weighted_pick_with_exclusions #(
	parameter int NUM_ENTRIES = wpwe_pkg::NUM_ENTRIES_DEF,
	parameter int WEIGHT_BITS = wpwe_pkg::WEIGHT_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  wpwe_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output wpwe_pkg::rsp_t  rsp
);

	// Address width, and an accumulator wide enough for the exact sum and for the draw value.
	localparam int AW       = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
	localparam int SUM_BITS = WEIGHT_BITS + AW;
	localparam int ACC_BITS = (SUM_BITS > wpwe_pkg::DRAW_W) ? SUM_BITS : wpwe_pkg::DRAW_W;
	localparam logic [AW-1:0]       LAST_ADDR = AW'(NUM_ENTRIES - 1);
	localparam logic [ACC_BITS-1:0] TOTAL_MAX = ACC_BITS'({wpwe_pkg::TOTAL_W{1'b1}});

	typedef enum logic [4:0] {
		S_INIT  = 5'b00001,
		S_IDLE  = 5'b00010,
		S_CLEAR = 5'b00100,
		S_DRAW  = 5'b01000,
		S_DRAIN = 5'b10000
	} state_t;

	// Storage.
	logic [WEIGHT_BITS-1:0] wmem [NUM_ENTRIES];
	logic                   xmem [NUM_ENTRIES];

	state_t                      state_q;
	logic [AW-1:0]               cnt_q;
	logic [wpwe_pkg::DRAW_W-1:0] draw_q;
	logic [ACC_BITS-1:0]         acc_q;
	logic                        found_q;
	logic [AW-1:0]               pick_q;

	logic                   rd_vld_s1;
	logic                   rd_last_s1;
	logic [AW-1:0]          rd_idx_s1;
	logic [WEIGHT_BITS-1:0] rd_w_s1;
	logic                   rd_x_s1;

	logic           res_pend_q;
	wpwe_pkg::rsp_t res_q;
	logic           rsp_valid_q;
	wpwe_pkg::rsp_t rsp_q;

	logic                   accept;
	logic                   idx_ok;
	logic [AW-1:0]          req_addr;
	logic                   w_we;
	logic [AW-1:0]          w_addr;
	logic [WEIGHT_BITS-1:0] w_data;
	logic                   x_we;
	logic [AW-1:0]          x_addr;
	logic                   x_data;
	logic                   cnt_last;
	logic [ACC_BITS-1:0]    add_w;
	logic [ACC_BITS-1:0]    run_next;
	logic                   found_next;
	logic [AW-1:0]          pick_next;
	logic [wpwe_pkg::TOTAL_W-1:0] total_sat;
	wpwe_pkg::rsp_t         draw_res;
	wpwe_pkg::rsp_t         ack_res;
	logic                   draw_done;
	logic                   set_pend;
	logic                   move;

	// A new request is taken only in idle and only when no earlier response is still pending
	// behind the output register.
	assign req_stall = (state_q != S_IDLE) || res_pend_q;
	assign accept    = req_valid && !req_stall;
	assign idx_ok    = 32'(req.entry_index) < 32'(NUM_ENTRIES);
	assign req_addr  = AW'(req.entry_index);
	assign cnt_last  = (cnt_q == LAST_ADDR);

	// Memory write port selection: the reset pass clears both memories, clear-all sweeps the
	// marks, and single-entry commands write at the addressed entry.
	always_comb begin
		w_we   = 1'b0;
		w_addr = cnt_q;
		w_data = '0;
		x_we   = 1'b0;
		x_addr = cnt_q;
		x_data = 1'b0;
		case (state_q)
			S_INIT: begin
				w_we = 1'b1;
				x_we = 1'b1;
			end
			S_CLEAR: begin
				x_we = 1'b1;
			end
			S_IDLE: begin
				if (accept && idx_ok) begin
					case (req.cmd)
						wpwe_pkg::CMD_WRITE: begin
							w_we   = 1'b1;
							w_addr = req_addr;
							w_data = WEIGHT_BITS'(req.weight_value);
						end
						wpwe_pkg::CMD_SET_EXCL: begin
							x_we   = 1'b1;
							x_addr = req_addr;
							x_data = 1'b1;
						end
						wpwe_pkg::CMD_CLR_EXCL: begin
							x_we   = 1'b1;
							x_addr = req_addr;
							x_data = 1'b0;
						end
						default: begin
						end
					endcase
				end
			end
			default: begin
			end
		endcase
	end

	// Draw datapath: one entry per cycle is added to the running sum, and the first index at
	// which the sum passes the draw value is kept.
	assign add_w      = rd_x_s1 ? '0 : ACC_BITS'(rd_w_s1);
	assign run_next   = acc_q + add_w;
	assign found_next = found_q || (run_next > ACC_BITS'(draw_q));
	assign pick_next  = found_q ? pick_q : rd_idx_s1;
	assign total_sat  = (run_next > TOTAL_MAX) ? TOTAL_MAX[wpwe_pkg::TOTAL_W-1:0]
	                                           : run_next[wpwe_pkg::TOTAL_W-1:0];

	always_comb begin
		draw_res = '0;
		if (run_next == '0) begin
			draw_res.status = wpwe_pkg::ST_EMPTY;
		end else if (!found_next) begin
			draw_res.status       = wpwe_pkg::ST_RANGE;
			draw_res.total_weight = total_sat;
		end else begin
			draw_res.picked_index = wpwe_pkg::IDX_W'(pick_next);
			draw_res.status       = wpwe_pkg::ST_OK;
			draw_res.total_weight = total_sat;
		end
	end

	assign ack_res   = '0;
	assign draw_done = rd_vld_s1 && rd_last_s1;
	assign set_pend  = (accept && (req.cmd != wpwe_pkg::CMD_DRAW)) || draw_done;
	assign move      = res_pend_q && (!rsp_valid_q || !rsp_stall);

	// Weight memory: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (w_we) begin
			wmem[w_addr] <= w_data;
		end
		rd_w_s1 <= wmem[cnt_q];
	end

	// Exclusion mark memory: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (x_we) begin
			xmem[x_addr] <= x_data;
		end
		rd_x_s1 <= xmem[cnt_q];
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		rd_idx_s1 <= cnt_q;
		if (accept) begin
			draw_q <= req.draw_value;
		end
		if (draw_done) begin
			res_q <= draw_res;
		end else if (set_pend) begin
			res_q <= ack_res;
		end
		if (move) begin
			rsp_q <= res_q;
		end
	end

	// Control: sequencer, draw accumulator and response handoff.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			cnt_q       <= '0;
			acc_q       <= '0;
			found_q     <= 1'b0;
			pick_q      <= '0;
			rd_vld_s1   <= 1'b0;
			rd_last_s1  <= 1'b0;
			res_pend_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			rd_vld_s1  <= (state_q == S_DRAW);
			rd_last_s1 <= cnt_last;

			case (state_q)
				S_INIT, S_CLEAR: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_last) begin
						cnt_q   <= '0;
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						case (req.cmd)
							wpwe_pkg::CMD_CLR_ALL: begin
								state_q <= S_CLEAR;
							end
							wpwe_pkg::CMD_DRAW: begin
								state_q <= S_DRAW;
								acc_q   <= '0;
								found_q <= 1'b0;
							end
							default: begin
							end
						endcase
					end
				end
				S_DRAW: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_last) begin
						cnt_q   <= '0;
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (draw_done) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_INIT;
					cnt_q   <= '0;
				end
			endcase

			if (rd_vld_s1) begin
				acc_q   <= run_next;
				found_q <= found_next;
				pick_q  <= pick_next;
			end

			if (move) begin
				res_pend_q <= 1'b0;
			end
			if (set_pend) begin
				res_pend_q <= 1'b1;
			end

			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (move) begin
				rsp_valid_q <= 1'b1;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Read data only arrives while a draw is walking the table.
	a_read_in_draw: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> (state_q == S_DRAW) || (state_q == S_DRAIN))
		else $error("table read data outside a draw");

	// The last entry of a walk ends the draw with a pending response.
	a_draw_ends: assert property (@(posedge clk) disable iff (!arst_n)
		draw_done |=> (state_q == S_IDLE) && res_pend_q)
		else $error("draw did not complete into a pending response");

	// A pending response is held while the output register is stalled.
	a_pend_held: assert property (@(posedge clk) disable iff (!arst_n)
		res_pend_q && rsp_valid && rsp_stall |=> res_pend_q && $stable(res_q))
		else $error("pending response lost under stall");

	// No request is taken during the clearing passes.
	a_no_accept_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INIT) || (state_q == S_CLEAR) |-> req_stall)
		else $error("request accepted during a clearing pass");

endmodule

// File: sim/weighted_pick_with_exclusions_test.sv
// Self-checking testbench for the weighted pick block with per-entry exclusion marks.
`timescale 1ns / 100ps

module weighted_pick_with_exclusions_test;

	localparam int N_ENTRIES   = wpwe_pkg::NUM_ENTRIES_DEF;
	localparam int IDX_MAX     = N_ENTRIES - 1;
	localparam int CMD_CODES   = 1 << wpwe_pkg::CMD_W;
	localparam longint TOTAL_MAX = (longint'(1) << wpwe_pkg::TOTAL_W) - 1;
	// A draw or a clear-all walks the whole table, so the tail wait covers one such walk.
	localparam int TAIL_CYCLES = N_ENTRIES + 16;
	// The limit covers a run in which every request walks the whole table, plus stalls, several times over.
	localparam longint CYCLE_LIMIT = 3000000;
	localparam int HOLD_CYCLES = 3000;
	localparam int MAX_PRINTS  = 50;

	logic            clk;
	logic            arst_n    = 1'b0;
	logic            req_valid = 1'b0;
	logic            req_stall;
	wpwe_pkg::req_t  req       = '0;
	logic            rsp_valid;
	logic            rsp_stall = 1'b0;
	wpwe_pkg::rsp_t  rsp;

	weighted_pick_with_exclusions dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// Requests waiting to be offered, and the responses the predictor expects, oldest first.
	wpwe_pkg::req_t pending_reqs[$];
	wpwe_pkg::rsp_t expected_picks[$];
	int     queued_reqs   = 0;
	int     accepted_reqs = 0;
	int     mismatches    = 0;
	longint cycle_count   = 0;

	// Idle percentages for the current phase and the long receiver hold-off.
	int send_idle_pct = 0;
	int rsp_stall_pct = 0;
	int rsp_hold_left = 0;
	logic req_taken = 1'b0;

	// Predictor state: the weight table and exclusion marks as the block should hold them.
	logic [wpwe_pkg::WIN_W-1:0] wt_mem [N_ENTRIES];
	bit                         excl_mark [N_ENTRIES];

	// Stimulus-side shadow of the same state, used only to aim draw values at the total.
	logic [wpwe_pkg::WIN_W-1:0] gen_wt [N_ENTRIES];
	bit                         gen_excl [N_ENTRIES];

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic report(input string what, input int got, input int want);
		if (mismatches < MAX_PRINTS)
			$display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
		mismatches++;
	endtask

	// Applies one command to the predictor state and returns the response it must produce.
	// A draw sums the weights of entries that are not excluded, then walks the table in
	// index order and picks the first entry at which the running sum passes the draw value.
	function automatic wpwe_pkg::rsp_t pick_outcome(input wpwe_pkg::req_t r);
		wpwe_pkg::rsp_t o;
		longint sum;
		longint run;
		bit     found;
		o = '0;
		sum = 0;
		run = 0;
		found = 1'b0;
		case (r.cmd)
			wpwe_pkg::CMD_WRITE:    wt_mem[r.entry_index] = r.weight_value;
			wpwe_pkg::CMD_SET_EXCL: excl_mark[r.entry_index] = 1'b1;
			wpwe_pkg::CMD_CLR_EXCL: excl_mark[r.entry_index] = 1'b0;
			wpwe_pkg::CMD_CLR_ALL:  excl_mark = '{default: 1'b0};
			wpwe_pkg::CMD_DRAW: begin
				for (int i = 0; i < N_ENTRIES; i++)
					if (!excl_mark[i])
						sum += wt_mem[i];
				if (sum == 0) begin
					o.status = wpwe_pkg::ST_EMPTY;
				end else begin
					o.total_weight = wpwe_pkg::TOTAL_W'((sum > TOTAL_MAX) ? TOTAL_MAX : sum);
					if (r.draw_value >= sum) begin
						o.status = wpwe_pkg::ST_RANGE;
					end else begin
						o.status = wpwe_pkg::ST_OK;
						for (int i = 0; i < N_ENTRIES && !found; i++) begin
							if (!excl_mark[i])
								run += wt_mem[i];
							if (run > r.draw_value) begin
								o.picked_index = wpwe_pkg::IDX_W'(i);
								found = 1'b1;
							end
						end
					end
				end
			end
			default: ;
		endcase
		return o;
	endfunction

	function automatic longint gen_total();
		longint s;
		s = 0;
		for (int i = 0; i < N_ENTRIES; i++)
			if (!gen_excl[i])
				s += gen_wt[i];
		return s;
	endfunction

	// Queues one request transaction and keeps the stimulus shadow in step with it.
	task automatic queue_item(input logic [wpwe_pkg::CMD_W-1:0] cmd,
			input logic [wpwe_pkg::IDX_W-1:0] idx,
			input logic [wpwe_pkg::WIN_W-1:0] wv, input logic [wpwe_pkg::DRAW_W-1:0] dv);
		wpwe_pkg::req_t r;
		r.cmd = cmd;
		r.entry_index = idx;
		r.weight_value = wv;
		r.draw_value = dv;
		case (cmd)
			wpwe_pkg::CMD_WRITE:    gen_wt[idx] = wv;
			wpwe_pkg::CMD_SET_EXCL: gen_excl[idx] = 1'b1;
			wpwe_pkg::CMD_CLR_EXCL: gen_excl[idx] = 1'b0;
			wpwe_pkg::CMD_CLR_ALL:  gen_excl = '{default: 1'b0};
			default: ;
		endcase
		pending_reqs = {pending_reqs, r};
		queued_reqs++;
	endtask

	// Returns once every queued transaction was accepted and every response checked.
	task automatic wait_drained();
		while (accepted_reqs != queued_reqs || expected_picks.size() != 0)
			@(negedge clk);
	endtask

	// Random phase. Most traffic targets a few entries at both ends of the table so that
	// writes, exclusions and draws interact; the rest addresses the whole table.
	task automatic run_phase(input int count, input int send_pct, input int stall_pct);
		int                             sel;
		int                             pick;
		longint                         total;
		logic [wpwe_pkg::CMD_W-1:0]     cmd;
		logic [wpwe_pkg::IDX_W-1:0]     idx;
		logic [wpwe_pkg::WIN_W-1:0]     wv;
		logic [wpwe_pkg::DRAW_W-1:0]    dv;
		send_idle_pct = send_pct;
		rsp_stall_pct = stall_pct;
		for (int n = 0; n < count; n++) begin
			sel = $urandom_range(99);
			if (sel < 30)
				cmd = wpwe_pkg::CMD_WRITE;
			else if (sel < 42)
				cmd = wpwe_pkg::CMD_SET_EXCL;
			else if (sel < 54)
				cmd = wpwe_pkg::CMD_CLR_EXCL;
			else if (sel < 57)
				cmd = wpwe_pkg::CMD_CLR_ALL;
			else if (sel < 93)
				cmd = wpwe_pkg::CMD_DRAW;
			else
				cmd = wpwe_pkg::CMD_W'($urandom_range(CMD_CODES - 1,
					int'(wpwe_pkg::CMD_DRAW) + 1));

			if ($urandom_range(3) == 0)
				idx = wpwe_pkg::IDX_W'($urandom);
			else if ($urandom_range(1) == 0)
				idx = wpwe_pkg::IDX_W'($urandom_range(7));
			else
				idx = wpwe_pkg::IDX_W'(IDX_MAX - int'($urandom_range(7)));

			case ($urandom_range(3))
				0: wv = wpwe_pkg::WIN_W'($urandom);
				1: wv = wpwe_pkg::WIN_W'($urandom_range(15));
				2: wv = '1;
				default: wv = wpwe_pkg::WIN_W'($urandom_range(4095));
			endcase

			// Draw values land mostly inside the eligible total, with the boundaries and
			// fully random values mixed in.
			total = gen_total();
			pick = $urandom_range(9);
			if (cmd != wpwe_pkg::CMD_DRAW || total == 0 || pick == 0)
				dv = wpwe_pkg::DRAW_W'($urandom);
			else if (pick == 1)
				dv = wpwe_pkg::DRAW_W'(total);
			else if (pick == 2)
				dv = wpwe_pkg::DRAW_W'(total - 1);
			else
				dv = wpwe_pkg::DRAW_W'($urandom_range(32'(total - 1), 0));

			queue_item(cmd, idx, wv, dv);
		end
		wait_drained();
	endtask

	// Driver: offers the next pending transaction at the falling edge and holds a stalled one.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!req_valid || req_taken) begin
				if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					req <= pending_reqs.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk)
		req_taken <= req_valid && (req_stall === 1'b0);

	// Receiver stall. A long hold-off, when requested, is counted down here before the
	// phase's random stalling resumes.
	always @(negedge clk) begin
		if (rsp_hold_left > 0) begin
			rsp_stall <= 1'b1;
			rsp_hold_left <= rsp_hold_left - 1;
		end else begin
			rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
		end
	end

	// Monitor: checks each accepted response against the oldest expectation, then records
	// the expectation for a request accepted at the same edge.
	always @(posedge clk) begin
		wpwe_pkg::rsp_t want;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_picks.size() == 0) begin
					report("response with no request outstanding", int'(rsp.picked_index), 0);
				end else begin
					want = expected_picks.pop_front();
					if (rsp.picked_index !== want.picked_index)
						report("picked_index", int'(rsp.picked_index),
							int'(want.picked_index));
					if (rsp.status !== want.status)
						report("status", int'(rsp.status), int'(want.status));
					if (rsp.total_weight !== want.total_weight)
						report("total_weight", int'(rsp.total_weight),
							int'(want.total_weight));
				end
			end
			if (req_valid && !req_stall) begin
				expected_picks = {expected_picks, pick_outcome(req)};
				accepted_reqs++;
			end
		end
	end

	initial begin
		wt_mem = '{default: '0};
		excl_mark = '{default: 1'b0};
		gen_wt = '{default: '0};
		gen_excl = '{default: 1'b0};

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// Directed part. The table starts empty, so the first draw has no weight to pick from.
		queue_item(wpwe_pkg::CMD_DRAW, 0, 0, 0);
		// Heaviest weights at both ends of the table and a unit weight in the middle.
		queue_item(wpwe_pkg::CMD_WRITE, 0, '1, 0);
		queue_item(wpwe_pkg::CMD_WRITE, wpwe_pkg::IDX_W'(IDX_MAX), '1, 0);
		queue_item(wpwe_pkg::CMD_WRITE, 512, 1, 0);
		// Draws at the boundaries of each entry's slice of the wheel.
		queue_item(wpwe_pkg::CMD_DRAW, 0, 0, 0);
		queue_item(wpwe_pkg::CMD_DRAW, 0, 0, 65535);
		queue_item(wpwe_pkg::CMD_DRAW, 0, 0, 131070);
		// A draw equal to the total and the largest draw value are both out of range.
		queue_item(wpwe_pkg::CMD_DRAW, 0, 0, 131071);
		queue_item(wpwe_pkg::CMD_DRAW, '1, '1, '1);
		// Excluding the first entry moves a zero draw on to the middle entry.
		queue_item(wpwe_pkg::CMD_SET_EXCL, 0, '1, '1);
		queue_item(wpwe_pkg::CMD_DRAW, 0, 0, 0);
		// With every weighted entry excluded there is no remaining weight.
		queue_item(wpwe_pkg::CMD_SET_EXCL, 512, 0, 0);
		queue_item(wpwe_pkg::CMD_SET_EXCL, wpwe_pkg::IDX_W'(IDX_MAX), 0, 0);
		queue_item(wpwe_pkg::CMD_DRAW, 0, 0, 5);
		queue_item(wpwe_pkg::CMD_CLR_EXCL, 512, '1, '1);
		queue_item(wpwe_pkg::CMD_DRAW, 0, 0, 0);
		queue_item(wpwe_pkg::CMD_CLR_ALL, '1, '1, '1);
		queue_item(wpwe_pkg::CMD_DRAW, 0, 0, 65536);
		// Unused command codes must leave the table alone and still be acknowledged.
		for (int c = int'(wpwe_pkg::CMD_DRAW) + 1; c < CMD_CODES; c++)
			queue_item(wpwe_pkg::CMD_W'(c), '1, '1, '1);
		// A zero weight is skipped by the walk.
		queue_item(wpwe_pkg::CMD_WRITE, wpwe_pkg::IDX_W'(IDX_MAX), 0, 0);
		queue_item(wpwe_pkg::CMD_DRAW, 0, 0, 65535);
		queue_item(wpwe_pkg::CMD_DRAW, 0, 0, 65536);
		wait_drained();

		// No idling from the sender while the receiver holds off for a long stretch, so the
		// block fills up and stalls its input. Each phase ends with the sender paused until
		// every response has been checked.
		rsp_hold_left = HOLD_CYCLES;
		run_phase(140, 0, 0);
		run_phase(140, 65, 0);
		run_phase(140, 0, 65);
		run_phase(140, 23, 23);

		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_picks.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// File: sim.f
design/wpwe_pkg.sv
design/weighted_pick_with_exclusions.sv
sim/weighted_pick_with_exclusions_test.sv
